FILE: src/bts_pkg.sv
`timescale 1ns / 1ps

package bts_pkg;

    localparam int MAX_ENTRIES = 40;
    localparam int CYL_W       = 16;
    localparam int HEAD_W      = 8;
    localparam int ENTRY_W     = CYL_W + HEAD_W;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int FIELD_IDX_W = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT = 2'd1;

    localparam logic [CYL_W-1:0]  CYL_COUNT_RST  = 16'd100;
    localparam logic [HEAD_W-1:0] HEAD_COUNT_RST = 8'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_READ_OK   = 3'd4,
        ST_BAD_INDEX = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage

FILE: src/bad_track_sorted_insert_top.sv
`timescale 1ns / 1ps
// Throughput: one command at a time; busy is high until the result word is out.
// The single-port table memory sets the insert time: every search and shift step reads it.
// Reset: synchronous active low; table empty, geometry 100 cylinders and 2 heads.
// The result strobe lasts one cycle and the receiver cannot stall it.

module bad_track_sorted_insert_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_cmd,
    input  logic [bts_pkg::CYL_W-1:0]          i_track_cylinder,
    input  logic [bts_pkg::HEAD_W-1:0]         i_track_head,
    input  logic [bts_pkg::FIELD_IDX_W-1:0]    i_entry_index,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bts_pkg::CYL_W-1:0]          i_cfg_data,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [bts_pkg::FIELD_IDX_W-1:0]    o_position,
    output logic [bts_pkg::FIELD_IDX_W-1:0]    o_entry_total,
    output logic [bts_pkg::CYL_W-1:0]          o_read_cylinder,
    output logic [bts_pkg::HEAD_W-1:0]         o_read_head
);
    import bts_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SRD   = 9'b000000010,
        S_SCMP  = 9'b000000100,
        S_PLACE = 9'b000001000,
        S_HRD   = 9'b000010000,
        S_HWR   = 9'b000100000,
        S_INS   = 9'b001000000,
        S_RRD   = 9'b010000000,
        S_RDAT  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [CYL_W-1:0]    r_key_cyl, n_key_cyl;
    logic [HEAD_W-1:0]   r_key_head, n_key_head;
    logic [CYL_W-1:0]    r_cyl_count;
    logic [HEAD_W-1:0]   r_head_count;

    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic [FIELD_IDX_W-1:0] r_position, n_position;
    logic [FIELD_IDX_W-1:0] r_total, n_total;
    logic [CYL_W-1:0]    r_rcyl, n_rcyl;
    logic [HEAD_W-1:0]   r_rhead, n_rhead;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_cmp_res            cmp;
    logic [CNT_W-1:0]    idx_dec;
    logic [CNT_W-1:0]    idx_inc;

    bts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bts_cmp u_cmp (
        .i_key_cyl  (r_key_cyl),
        .i_key_head (r_key_head),
        .i_ent_cyl  (ram_rdata[ENTRY_W-1:HEAD_W]),
        .i_ent_head (ram_rdata[HEAD_W-1:0]),
        .o_res      (cmp)
    );

    assign idx_dec = r_idx - CNT_W'(1);
    assign idx_inc = r_idx + CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_key_cyl  = r_key_cyl;
        n_key_head = r_key_head;
        n_done     = 1'b0;
        n_status   = r_status;
        n_position = r_position;
        n_total    = r_total;
        n_rcyl     = r_rcyl;
        n_rhead    = r_rhead;
        ram_we     = 1'b0;
        ram_addr   = r_idx[ADDR_W-1:0];
        ram_wdata  = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_done     = 1'b1;
                    n_status   = ST_BAD_INDEX;
                    n_position = '0;
                    n_total    = FIELD_IDX_W'(r_fill);
                    n_rcyl     = '0;
                    n_rhead    = '0;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (i_track_cylinder >= r_cyl_count ||
                                i_track_head >= r_head_count) begin
                                n_status = ST_RANGE;
                            end else begin
                                // hold the result until the table work is done
                                n_done     = 1'b0;
                                n_key_cyl  = i_track_cylinder;
                                n_key_head = i_track_head;
                                n_idx      = '0;
                                if (r_fill == '0) begin
                                    n_pos   = '0;
                                    n_state = S_PLACE;
                                end else begin
                                    n_state = S_SRD;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (8'(i_entry_index) < 8'(r_fill)) begin
                                n_done  = 1'b0;
                                n_idx   = CNT_W'(i_entry_index);
                                n_state = S_RRD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill   = '0;
                            n_status = ST_CLEARED;
                            n_total  = '0;
                        end
                        default: begin
                            n_status = ST_BAD_INDEX;
                        end
                    endcase
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (cmp.eq) begin
                    n_done     = 1'b1;
                    n_status   = ST_DUPLICATE;
                    n_position = FIELD_IDX_W'(r_idx);
                    n_total    = FIELD_IDX_W'(r_fill);
                    n_rcyl     = '0;
                    n_rhead    = '0;
                    n_state    = S_IDLE;
                end else if (cmp.gt) begin
                    n_pos   = r_idx;
                    n_state = S_PLACE;
                end else if (idx_inc == r_fill) begin
                    // larger than every entry: append
                    n_pos   = r_fill;
                    n_state = S_PLACE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SRD;
                end
            end
            S_PLACE: begin
                if (r_fill >= CNT_W'(MAX_ENTRIES)) begin
                    n_done     = 1'b1;
                    n_status   = ST_FULL;
                    n_position = '0;
                    n_total    = FIELD_IDX_W'(r_fill);
                    n_rcyl     = '0;
                    n_rhead    = '0;
                    n_state    = S_IDLE;
                end else if (r_fill == r_pos) begin
                    n_state = S_INS;
                end else begin
                    n_idx   = r_fill;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                ram_addr = idx_dec[ADDR_W-1:0];
                n_state  = S_HWR;
            end
            S_HWR: begin
                // move the word read from below up one place
                ram_we    = 1'b1;
                ram_addr  = r_idx[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                n_idx     = idx_dec;
                n_state   = (idx_dec == r_pos) ? S_INS : S_HRD;
            end
            S_INS: begin
                ram_we     = 1'b1;
                ram_addr   = r_pos[ADDR_W-1:0];
                ram_wdata  = {r_key_cyl, r_key_head};
                n_fill     = r_fill + CNT_W'(1);
                n_done     = 1'b1;
                n_status   = ST_INSERTED;
                n_position = FIELD_IDX_W'(r_pos);
                n_total    = FIELD_IDX_W'(r_fill + CNT_W'(1));
                n_rcyl     = '0;
                n_rhead    = '0;
                n_state    = S_IDLE;
            end
            S_RRD: begin
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_done     = 1'b1;
                n_status   = ST_READ_OK;
                n_position = FIELD_IDX_W'(r_idx);
                n_total    = FIELD_IDX_W'(r_fill);
                n_rcyl     = ram_rdata[ENTRY_W-1:HEAD_W];
                n_rhead    = ram_rdata[HEAD_W-1:0];
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_done       <= 1'b0;
            r_cyl_count  <= CYL_COUNT_RST;
            r_head_count <= HEAD_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_CYL_COUNT) begin
                    r_cyl_count <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEAD_COUNT) begin
                    r_head_count <= i_cfg_data[HEAD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_key_cyl  <= n_key_cyl;
        r_key_head <= n_key_head;
        r_status   <= n_status;
        r_position <= n_position;
        r_total    <= n_total;
        r_rcyl     <= n_rcyl;
        r_rhead    <= n_rhead;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_position      = r_position;
    assign o_entry_total   = r_total;
    assign o_read_cylinder = r_rcyl;
    assign o_read_head     = r_rhead;

endmodule

FILE: src/bts_ram.sv
`timescale 1ns / 1ps

module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bts_cmp.sv
`timescale 1ns / 1ps

module bts_cmp (
    input  logic [bts_pkg::CYL_W-1:0]  i_key_cyl,
    input  logic [bts_pkg::HEAD_W-1:0] i_key_head,
    input  logic [bts_pkg::CYL_W-1:0]  i_ent_cyl,
    input  logic [bts_pkg::HEAD_W-1:0] i_ent_head,
    output bts_pkg::t_cmp_res          o_res
);
    import bts_pkg::*;

    logic cyl_eq;

    assign cyl_eq   = (i_ent_cyl == i_key_cyl);
    assign o_res.eq = cyl_eq && (i_ent_head == i_key_head);
    // entry orders after the key: cylinder first, then head
    assign o_res.gt = (i_ent_cyl > i_key_cyl) || (cyl_eq && (i_ent_head > i_key_head));

endmodule
